// File: rtl/tpsf_pkg.sv
package tpsf_pkg;

    localparam int D_W      = 33;
    localparam int SQ_W     = 66;
    localparam int ROOT_W   = 33;
    localparam int SQRT_N   = 34;
    localparam int SQRT_REM = 36;
    localparam int MAG_W    = 48;
    localparam int NUM_W    = 81;
    localparam int DIV_N    = 33;
    localparam int CFG_W    = 31;

    localparam logic CFG_REST   = 1'b0;
    localparam logic CFG_SPRING = 1'b1;

    localparam logic [CFG_W-1:0] REST_RESET   = 31'd65536;
    localparam logic [CFG_W-1:0] SPRING_RESET = 31'd65536;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][D_W-1:0] ad;
    } sqrt_side_t;

    typedef struct packed {
        logic neg;
        logic kill;
    } div_side_t;

endpackage

// File: rtl/tpsf_sqrt.sv
module tpsf_sqrt
    import tpsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              valid_in,
    input  logic [SQ_W-1:0]   rad_in,
    input  sqrt_side_t        side_in,
    output logic              valid_out,
    output logic [ROOT_W-1:0] root_out,
    output sqrt_side_t        side_out
);

    logic                valid_reg [0:SQRT_N];
    logic [SQRT_REM-1:0] rem_reg   [0:SQRT_N];
    logic [SQRT_N-1:0]   root_reg  [0:SQRT_N];
    logic [SQ_W+1:0]     rad_reg   [0:SQRT_N];
    sqrt_side_t          side_reg  [0:SQRT_N];

    logic [SQRT_REM-1:0] rem_next  [0:SQRT_N-1];
    logic [SQRT_N-1:0]   root_next [0:SQRT_N-1];

    always_comb
    begin
        for (int i = 0; i < SQRT_N; i++)
        begin
            logic [SQRT_REM-1:0] rem_sh;
            logic [SQRT_REM-1:0] trial;
            rem_sh = {rem_reg[i][SQRT_REM-3:0], rad_reg[i][SQ_W+1:SQ_W]};
            trial  = {root_reg[i], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[i]  = rem_sh - trial;
                root_next[i] = {root_reg[i][SQRT_N-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = rem_sh;
                root_next[i] = {root_reg[i][SQRT_N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQRT_N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= valid_in;
            for (int i = 0; i < SQRT_N; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rad_reg[0]  <= {2'b00, rad_in};
            side_reg[0] <= side_in;
            for (int i = 0; i < SQRT_N; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                root_reg[i+1] <= root_next[i];
                rad_reg[i+1]  <= {rad_reg[i][SQ_W-1:0], 2'b00};
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign valid_out = valid_reg[SQRT_N];
    assign root_out  = root_reg[SQRT_N][ROOT_W-1:0];
    assign side_out  = side_reg[SQRT_N];

endmodule

// File: rtl/tpsf_div.sv
module tpsf_div
    import tpsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              valid_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [ROOT_W-1:0] den_in,
    input  div_side_t         side_in,
    output logic              valid_out,
    output logic [DIV_N-1:0]  quot_out,
    output logic              ovf_out,
    output div_side_t         side_out
);

    logic              valid_reg [0:DIV_N];
    logic [ROOT_W-1:0] rem_reg   [0:DIV_N];
    logic [DIV_N-1:0]  low_reg   [0:DIV_N];
    logic [DIV_N-1:0]  quot_reg  [0:DIV_N];
    logic [ROOT_W-1:0] den_reg   [0:DIV_N];
    logic              ovf_reg   [0:DIV_N];
    div_side_t         side_reg  [0:DIV_N];

    logic [ROOT_W-1:0] rem_next [0:DIV_N-1];
    logic              bit_next [0:DIV_N-1];

    always_comb
    begin
        for (int i = 0; i < DIV_N; i++)
        begin
            logic [ROOT_W:0] rem_sh;
            logic [ROOT_W:0] diff;
            rem_sh = {rem_reg[i], low_reg[i][DIV_N-1]};
            diff   = rem_sh - {1'b0, den_reg[i]};
            bit_next[i] = (rem_sh >= {1'b0, den_reg[i]});
            rem_next[i] = bit_next[i] ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= valid_in;
            for (int i = 0; i < DIV_N; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= num_in[NUM_W-16:DIV_N];
            low_reg[0]  <= num_in[DIV_N-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= den_in;
            ovf_reg[0]  <= (num_in[NUM_W-1:DIV_N] >= {15'd0, den_in});
            side_reg[0] <= side_in;
            for (int i = 0; i < DIV_N; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                low_reg[i+1]  <= {low_reg[i][DIV_N-2:0], 1'b0};
                quot_reg[i+1] <= {quot_reg[i][DIV_N-2:0], bit_next[i]};
                den_reg[i+1]  <= den_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign valid_out = valid_reg[DIV_N];
    assign quot_out  = quot_reg[DIV_N];
    assign ovf_out   = ovf_reg[DIV_N];
    assign side_out  = side_reg[DIV_N];

endmodule

// File: rtl/two_point_spring_force_top.sv
// Spring force on a particle from a spring to a second point, positions and forces are
// signed Q16.16. The block takes one item per cycle while item_stall is low: registers
// a to d form the separation and its squared length, a 35-register square-root
// pipeline gives the length, registers e to h form the magnitude and the three
// numerators, and a 34-register divider pipeline per component divides by the length
// before the output register. The whole pipeline holds while a result waits on a
// stalled output, so item_stall follows force_stall only when force_valid is high.
// Registers may be written only while no item is in flight.
module two_point_spring_force_top
    import tpsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_y,
    input  logic signed [31:0] other_z,
    output logic               force_valid,
    input  logic               force_stall,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z
);

    logic [CFG_W-1:0] rest_reg;
    logic [CFG_W-1:0] spring_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= REST_RESET;
            spring_reg <= SPRING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REST:   rest_reg   <= cfg_data;
                CFG_SPRING: spring_reg <= cfg_data;
                default:    rest_reg   <= rest_reg;
            endcase
        end
    end

    logic ce;
    logic force_valid_reg;

    assign ce         = !(force_valid_reg && force_stall);
    assign item_stall = !ce;

    logic                 valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic                 valid_e_reg, valid_f_reg, valid_g_reg, valid_h_reg;
    logic [2:0][D_W-1:0]  d_a_reg;
    logic [2:0][D_W-1:0]  ad_b_reg, ad_c_reg;
    logic [2:0]           neg_b_reg, neg_c_reg;
    logic [2:0][SQ_W-1:0] sq_c_reg;
    logic [SQ_W-1:0]      s_d_reg;
    sqrt_side_t           side_d_reg;
    sqrt_side_t           side_e_reg, side_f_reg, side_g_reg, side_h_reg;
    logic [ROOT_W-1:0]    m_e_reg, m_f_reg, m_g_reg, m_h_reg;
    logic [ROOT_W-1:0]    e_e_reg;
    logic [MAG_W-1:0]     mag_f_reg;
    logic [2:0][56:0]     pp_lo_g_reg, pp_hi_g_reg;
    logic [2:0][NUM_W-1:0] n_h_reg;

    logic [2:0][D_W-1:0]  d_next;
    logic [2:0][D_W-1:0]  ad_next;
    logic [2:0]           neg_next;

    assign d_next[0] = {pos_x[31], pos_x} - {other_x[31], other_x};
    assign d_next[1] = {pos_y[31], pos_y} - {other_y[31], other_y};
    assign d_next[2] = {pos_z[31], pos_z} - {other_z[31], other_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ad_next[i]  = d_a_reg[i][D_W-1] ? D_W'(-d_a_reg[i]) : d_a_reg[i];
            neg_next[i] = !d_a_reg[i][D_W-1] && (d_a_reg[i] != '0);
        end
    end

    logic              valid_sq;
    logic [ROOT_W-1:0] root_sq;
    sqrt_side_t        side_sq;

    logic [ROOT_W-1:0] e_next;
    logic [63:0]       mag_prod;

    assign e_next   = (root_sq >= {2'b00, rest_reg}) ? (root_sq - {2'b00, rest_reg})
                                                     : ({2'b00, rest_reg} - root_sq);
    assign mag_prod = e_e_reg * spring_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
            valid_h_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_a_reg <= item_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_sq;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
            valid_h_reg <= valid_g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_a_reg    <= d_next;
            ad_b_reg   <= ad_next;
            neg_b_reg  <= neg_next;
            ad_c_reg   <= ad_b_reg;
            neg_c_reg  <= neg_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_c_reg[i]    <= ad_b_reg[i] * ad_b_reg[i];
                pp_lo_g_reg[i] <= side_f_reg.ad[i] * mag_f_reg[23:0];
                pp_hi_g_reg[i] <= side_f_reg.ad[i] * mag_f_reg[47:24];
                n_h_reg[i]     <= {24'd0, pp_lo_g_reg[i]} + {pp_hi_g_reg[i], 24'd0};
            end
            s_d_reg        <= sq_c_reg[0] + sq_c_reg[1] + sq_c_reg[2];
            side_d_reg.ad  <= ad_c_reg;
            side_d_reg.neg <= neg_c_reg;
            m_e_reg    <= root_sq;
            e_e_reg    <= e_next;
            side_e_reg <= side_sq;
            m_f_reg    <= m_e_reg;
            mag_f_reg  <= mag_prod[63:16];
            side_f_reg <= side_e_reg;
            m_g_reg    <= m_f_reg;
            side_g_reg <= side_f_reg;
            m_h_reg    <= m_g_reg;
            side_h_reg <= side_g_reg;
        end
    end

    tpsf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .valid_in  (valid_d_reg),
        .rad_in    (s_d_reg),
        .side_in   (side_d_reg),
        .valid_out (valid_sq),
        .root_out  (root_sq),
        .side_out  (side_sq)
    );

    logic [2:0]             valid_dv;
    logic [2:0][DIV_N-1:0]  quot_dv;
    logic [2:0]             ovf_dv;
    div_side_t              side_dv [0:2];
    div_side_t              side_h  [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side_h[i].neg  = side_h_reg.neg[i];
            side_h[i].kill = (m_h_reg == '0);
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        tpsf_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .valid_in  (valid_h_reg),
            .num_in    (n_h_reg[g]),
            .den_in    (m_h_reg),
            .side_in   (side_h[g]),
            .valid_out (valid_dv[g]),
            .quot_out  (quot_dv[g]),
            .ovf_out   (ovf_dv[g]),
            .side_out  (side_dv[g])
        );
    end

    logic [2:0][31:0] force_next;
    logic [2:0][31:0] force_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (side_dv[i].kill)
            begin
                force_next[i] = '0;
            end
            else if (side_dv[i].neg)
            begin
                if (ovf_dv[i] || (quot_dv[i] > 33'h080000000))
                    force_next[i] = 32'h80000000;
                else
                    force_next[i] = 32'(-quot_dv[i]);
            end
            else
            begin
                if (ovf_dv[i] || (quot_dv[i] > 33'h07FFFFFFF))
                    force_next[i] = 32'h7FFFFFFF;
                else
                    force_next[i] = quot_dv[i][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            force_valid_reg <= valid_dv[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            force_reg <= force_next;
        end
    end

    assign force_valid = force_valid_reg;
    assign force_x     = force_reg[0];
    assign force_y     = force_reg[1];
    assign force_z     = force_reg[2];

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> force_valid_reg)
        else $error("input stalled with an empty output register");

    a_pipe_frozen : assert property (@(posedge clk) disable iff (!rst_n)
        (force_valid_reg && force_stall) |=> $stable(valid_h_reg) && $stable(n_h_reg))
        else $error("pipeline moved while the output was blocked");

    a_zero_root : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_e_reg && m_e_reg == '0) |->
            (side_e_reg.ad[0] == '0 && side_e_reg.ad[1] == '0 && side_e_reg.ad[2] == '0))
        else $error("zero length from a nonzero separation");

    a_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        valid_dv[0] == valid_dv[1] && valid_dv[1] == valid_dv[2])
        else $error("divider lanes out of step");

endmodule

// File: dv/spring_force_checker.sv
`timescale 1ns / 100ps

module spring_force_checker
    import tpsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_y,
    input  logic signed [31:0] other_z,
    input  logic               force_valid,
    input  logic               force_stall,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    output int                 fail_count,
    output int                 pending,
    output int                 forces_seen
);

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } force_vec_t;

    force_vec_t expected_forces[$];
    logic [CFG_W-1:0] rest_len;
    logic [CFG_W-1:0] stiffness;

    function automatic logic [65:0] root_floor(logic [65:0] s);
        logic [32:0] r;
        logic [32:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (33'd1 << b);
            if ({66'd0, c} * {66'd0, c} <= {66'd0, s})
                r = c;
        end
        return {33'd0, r};
    endfunction

    function automatic logic [31:0] pull_component(logic signed [32:0] d,
                                                   logic [63:0] mag, logic [32:0] m);
        logic [127:0] q;
        logic [32:0] ad;
        if (m == 0 || d == 0)
            return 32'd0;
        ad = d[32] ? 33'(-d) : 33'(d);
        q = ({95'd0, ad} * {64'd0, mag}) / {95'd0, m};
        if (!d[32])
            return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic force_vec_t spring_force(logic signed [31:0] px, py, pz,
                                                ox, oy, oz);
        logic signed [32:0] dx, dy, dz;
        logic [65:0] s;
        logic [32:0] m;
        logic [63:0] e, mag;
        force_vec_t f;
        dx = 33'(px) - 33'(ox);
        dy = 33'(py) - 33'(oy);
        dz = 33'(pz) - 33'(oz);
        s = 66'($unsigned(66'(dx) * 66'(dx))) + 66'($unsigned(66'(dy) * 66'(dy)))
            + 66'($unsigned(66'(dz) * 66'(dz)));
        m = 33'(root_floor(s));
        e = ({31'd0, m} >= {33'd0, rest_len}) ? {31'd0, m} - {33'd0, rest_len}
                                              : {33'd0, rest_len} - {31'd0, m};
        mag = (e * {33'd0, stiffness}) >> 16;
        f.fx = pull_component(dx, mag, m);
        f.fy = pull_component(dy, mag, m);
        f.fz = pull_component(dz, mag, m);
        return f;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        force_vec_t want;
        if (!rst_n) begin
            rest_len <= REST_RESET;
            stiffness <= SPRING_RESET;
            expected_forces.delete();
            fail_count <= 0;
            forces_seen <= 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_REST)
                    rest_len <= cfg_data;
                else
                    stiffness <= cfg_data;
            end
            if (item_valid && !item_stall)
                expected_forces = {expected_forces,
                                   spring_force(pos_x, pos_y, pos_z,
                                                other_x, other_y, other_z)};
            if (force_valid && !force_stall) begin
                forces_seen <= forces_seen + 1;
                if (expected_forces.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected force item %h %h %h", force_x, force_y,
                                 force_z);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_forces.pop_front();
                    if (want.fx !== force_x || want.fy !== force_y
                        || want.fz !== force_z) begin
                        if (fail_count < 10)
                            $display("force mismatch: expected %h %h %h got %h %h %h",
                                     want.fx, want.fy, want.fz, force_x, force_y,
                                     force_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_forces.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import tpsf_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               item_valid;
    logic               item_stall;
    logic signed [31:0] pos_x, pos_y, pos_z, other_x, other_y, other_z;
    logic               force_valid;
    logic               force_stall;
    logic signed [31:0] force_x, force_y, force_z;
    int                 fail_count;
    int                 pending;
    int                 forces_seen;
    int                 idle_pct;
    int                 stall_pct;
    int                 items_sent;
    longint             cycles;

    two_point_spring_force_top uut (.*);
    spring_force_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(posedge clk)
        force_stall <= ($urandom_range(99) < stall_pct);

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom;
            3: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
        endcase
    endfunction

    task automatic send_item(logic [31:0] px, py, pz, ox, oy, oz);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        other_x <= ox;
        other_y <= oy;
        other_z <= oz;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random_item();
        logic [31:0] a;
        a = pick_coord();
        if ($urandom_range(9) == 0)
            send_item(a, a, a, a, a, a);
        else if ($urandom_range(4) == 0)
            send_item(a, pick_coord(), pick_coord(), a + $urandom_range(70000),
                      pick_coord(), pick_coord());
        else
            send_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord());
    endtask

    task automatic drain_pipeline();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic index, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_REST;
        cfg_data = '0;
        item_valid = 1'b0;
        {pos_x, pos_y, pos_z, other_x, other_y, other_z} = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(0, 0, 0, 0, 0, 0);
        send_item(32'h10000, 0, 0, 0, 0, 0);
        send_item(0, 32'h30000, 0, 0, 0, 0);
        send_item(0, 0, 0, 0, 0, 32'h30000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0);
        send_item(32'h20000, 32'h20000, 32'h10000, 32'h10000, 32'h10000, 0);
        send_item(1, 0, 0, 0, 0, 0);
        drain_pipeline();
        write_reg(CFG_REST, 31'h7FFF_FFFF);
        write_reg(CFG_SPRING, 31'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
        send_item(1, 0, 0, 0, 0, 0);
        send_item(0, 0, 0, 32'h4000_0000, 32'hC000_0000, 0);
        drain_pipeline();
        write_reg(CFG_REST, 0);
        write_reg(CFG_SPRING, 0);
        send_item(32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        drain_pipeline();
        write_reg(CFG_SPRING, 31'h0000_0001);
        send_item(32'h7FFF_FFFF, 32'h1234_5678, 0, 0, 0, 0);
        send_item(5, 0, 0, 0, 0, 0);
        drain_pipeline();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 59; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 59; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            write_reg(CFG_REST, (phase == 5) ? 31'h7FFF_FFFF
                               : 31'($urandom_range(65536 * 64)));
            write_reg(CFG_SPRING, (phase == 6) ? 31'h7FFF_FFFF
                               : (phase == 7) ? 31'd0 : 31'($urandom));
            repeat (186) send_random_item();
            drain_pipeline();
        end

        $display("Sent %0d items through eight config and flow-control phases.",
                 items_sent);
        $display("Checked %0d force results.", forces_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
